// ----- design/ddo_pkg.sv -----
package ddo_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int ANG_FRAC = 28;
  localparam int ADV_SHIFT = 22 - FRAC_BITS;
  localparam int TURN_SHIFT = ANG_FRAC - FRAC_BITS;
  localparam int CORDIC_STEPS_DEF = 16;

  // Datapath widths of the serial units
  localparam int MUL_W = 32;
  localparam int DVD_W = 64;
  localparam int DIV_W = 40;
  localparam int CW = 34;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  // Request kinds
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_VEL = 2'd1;
  localparam logic [1:0] REQ_POWER = 2'd2;

  // Constants
  localparam int PI_Q28 = 843314857;
  localparam int HALF_PI_Q28 = 421657428;
  localparam int CORDIC_GAIN_Q28 = 163008219;
  localparam int US_PER_S = 1000000;
  localparam int ADV_DIV = 15625;
  localparam logic [DIV_W-1:0] TWO_PI_Q28 = 40'd1686629714;
  localparam logic [23:0] TIMER_MAX = 24'hFFFFFF;

  localparam logic [27:0] ATAN_Q28 [0:27] = '{
    28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
    28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
    28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
    28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128, 28'd64,
    28'd32, 28'd16, 28'd8, 28'd4, 28'd2
  };

  typedef struct packed {
    logic [1:0]         req_type;
    logic [23:0]        step_us;
    logic signed [31:0] linear_cmd;
    logic signed [31:0] turn_cmd;
    logic               power_on;
  } req_t;

  typedef struct packed {
    logic signed [31:0] left_rate;
    logic signed [31:0] right_rate;
    logic signed [31:0] left_angle;
    logic signed [31:0] right_angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    logic               motors_on;
  } rsp_t;

  typedef struct packed {
    logic signed [DVD_W-1:0] quot;
    logic [DIV_W-1:0]        rem;
    logic                    neg;
  } div_res_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Turn a remainder modulo two pi into an angle in [-pi, pi)
  function automatic logic signed [31:0] wrap_res(input logic [DIV_W-1:0] rem,
                                                  input logic neg);
    logic [DIV_W-1:0] s;
    logic [DIV_W-1:0] d;
    s = (neg && rem != '0) ? (TWO_PI_Q28 - rem) : rem;
    d = s - DIV_W'(PI_Q28);
    return d[31:0];
  endfunction

endpackage

// ----- design/ddo_mul.sv -----
module ddo_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [ddo_pkg::MUL_W:0]    a,
  input  logic signed [ddo_pkg::MUL_W:0]    b,
  output logic                              done,
  output logic signed [2*ddo_pkg::MUL_W-1:0] prod
);
  import ddo_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic [MUL_W-1:0] mcand;
  logic [MUL_W-1:0] hi;
  logic [MUL_W-1:0] lo;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [MUL_W:0]   a_mag;
  logic [MUL_W:0]   b_mag;
  logic [MUL_W:0]   sum;
  logic [2*MUL_W-1:0] mag;

  assign a_mag = a[MUL_W] ? unsigned'(-a) : unsigned'(a);
  assign b_mag = b[MUL_W] ? unsigned'(-b) : unsigned'(b);

  // Add the multiplicand when the low multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);

  // Shift-add one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand <= a_mag[MUL_W-1:0];
        lo <= b_mag[MUL_W-1:0];
        hi <= '0;
        neg <= a[MUL_W] ^ b[MUL_W];
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        hi <= sum[MUL_W:1];
        lo <= {sum[0], lo[MUL_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restore the sign
  assign mag = {hi, lo};
  assign prod = neg ? -signed'(mag) : signed'(mag);

endmodule

// ----- design/ddo_div.sv -----
module ddo_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [ddo_pkg::DVD_W-1:0] dvd,
  input  logic [ddo_pkg::DIV_W-1:0]      dvs,
  output logic                           done,
  output ddo_pkg::div_res_t              res
);
  import ddo_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs_r;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   part;
  logic [DIV_W+1:0] trial;

  // Trial subtract of the divisor from the shifted partial remainder
  assign part = {rem, quo[DVD_W-1]};
  assign trial = {1'b0, part} - {2'b0, dvs_r};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dvd[DVD_W-1] ? unsigned'(-dvd) : unsigned'(dvd);
        rem <= '0;
        dvs_r <= dvs;
        neg <= dvd[DVD_W-1];
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DVD_W-2:0], ~trial[DIV_W+1]};
        rem <= trial[DIV_W+1] ? part[DIV_W-1:0] : trial[DIV_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient truncates toward zero, remainder stays a magnitude
  always_comb begin
    res.quot = neg ? -signed'(quo) : signed'(quo);
    res.rem = rem;
    res.neg = neg;
  end

endmodule

// ----- design/ddo_cordic.sv -----
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] cos_v,
  output logic signed [31:0] sin_v
);
  import ddo_pkg::*;

  localparam int IDX_W = $clog2(STEPS);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic signed [CW-1:0] za;
  logic signed [CW-1:0] z0;
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic signed [CW-1:0] at;
  logic signed [CW-1:0] xn;
  logic signed [CW-1:0] yn;
  logic                 red_neg;
  logic                 neg;
  logic                 busy;
  logic [IDX_W-1:0]     idx;

  // Fold the angle into the right half plane
  always_comb begin
    za = CW'(angle);
    z0 = za;
    red_neg = 1'b0;
    if (za > CW'(HALF_PI_Q28)) begin
      z0 = za - CW'(PI_Q28);
      red_neg = 1'b1;
    end else if (za < -CW'(HALF_PI_Q28)) begin
      z0 = za + CW'(PI_Q28);
      red_neg = 1'b1;
    end
  end

  assign sx = x >>> idx;
  assign sy = y >>> idx;
  assign at = signed'(CW'(ATAN_Q28[idx]));

  // Rotate one micro-step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x <= CW'(CORDIC_GAIN_Q28);
        y <= '0;
        z <= z0;
        neg <= red_neg;
        idx <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - sy;
          y <= y + sx;
          z <= z - at;
        end else begin
          x <= x + sy;
          y <= y - sx;
          z <= z + at;
        end
        idx <= idx + 1'b1;
        if (idx == IDX_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Undo the half-turn fold
  assign xn = neg ? -x : x;
  assign yn = neg ? -y : y;
  assign cos_v = xn[31:0];
  assign sin_v = yn[31:0];

endmodule

// ----- design/diff_drive_odometry_core.sv -----
// Tick: a sequence of twelve divisions on the bit-serial divider and ten products on
// the bit-serial multiplier; with zero step time the last two of each are skipped.
// Velocity command: one product. Motor power and unknown requests are handled in the
// idle state. One item is in work at a time.
// Reset (synchronous, active high) restores the default geometry and timeout, clears
// pose, wheel angles, commands and the command timer, and turns the motors on.
module diff_drive_odometry_core #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  ddo_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output ddo_pkg::rsp_t                   rsp,
  input  logic                            cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ddo_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_VMUL  = 18'h00002,
    S_RATE  = 18'h00004,
    S_AMUL  = 18'h00008,
    S_ADIV  = 18'h00010,
    S_AWRAP = 18'h00020,
    S_TMUL  = 18'h00040,
    S_TMUL2 = 18'h00080,
    S_TDIV  = 18'h00100,
    S_DA    = 18'h00200,
    S_XMUL  = 18'h00400,
    S_YMUL  = 18'h00800,
    S_HWRAP = 18'h01000,
    S_LMUL  = 18'h02000,
    S_LDIV  = 18'h04000,
    S_TMULR = 18'h08000,
    S_TDIVR = 18'h10000,
    S_OUT   = 18'h20000
  } state_t;

  state_t state;

  // Configuration
  logic [18:0] sep;
  logic [16:0] rad;
  logic [23:0] tmo;

  // Persistent state
  logic signed [31:0] lcmd;
  logic signed [31:0] rcmd;
  logic [23:0]        since;
  logic               motors;
  logic signed [31:0] lang;
  logic signed [31:0] rang;
  logic signed [31:0] yaw;
  logic [31:0]        xpos;
  logic [31:0]        ypos;

  // Per-item working registers
  logic [23:0]        step_r;
  logic signed [31:0] lin_cmd;
  logic signed [31:0] trn_cmd;
  logic signed [31:0] wl;
  logic signed [31:0] wr;
  logic signed [31:0] vt;
  logic signed [31:0] d1;
  logic signed [31:0] d2;
  logic signed [31:0] dr;
  logic signed [31:0] da;
  logic signed [31:0] lin_r;
  logic signed [31:0] trn_r;
  logic               sd;
  logic               op_run;
  logic               cs_ok;

  // Unit connections
  logic                     mul_start;
  logic                     mul_done;
  logic signed [MUL_W:0]    mul_a;
  logic signed [MUL_W:0]    mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic                     div_start;
  logic                     div_done;
  logic signed [DVD_W-1:0]  div_dvd;
  logic [DIV_W-1:0]         div_dvs;
  div_res_t                 dres;
  logic                     cs_start;
  logic                     cs_done;
  logic signed [31:0]       cos_v;
  logic signed [31:0]       sin_v;

  // Derived values
  logic                     op_done;
  logic [24:0]              since_sum;
  logic [23:0]              since_new;
  logic signed [31:0]       cur_cmd;
  logic signed [31:0]       cur_w;
  logic signed [31:0]       cur_ang;
  logic signed [31:0]       q_sat;
  logic signed [31:0]       wrap_now;
  logic signed [32:0]       dsum;
  logic signed [32:0]       dsum_adj;
  logic signed [32:0]       dhalf;
  logic signed [63:0]       hv;
  logic signed [63:0]       lsum;
  logic signed [63:0]       rsum;

  ddo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ddo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .res   (dres)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cs_start),
    .angle (yaw),
    .done  (cs_done),
    .cos_v (cos_v),
    .sin_v (sin_v)
  );

  assign req_stall = (state != S_IDLE);

  // Saturating command timer
  assign since_sum = {1'b0, since} + {1'b0, req.step_us};
  assign since_new = since_sum[24] ? TIMER_MAX : since_sum[23:0];

  // Select the wheel in work
  assign cur_cmd = sd ? rcmd : lcmd;
  assign cur_w = sd ? wr : wl;
  assign cur_ang = sd ? rang : lang;

  assign q_sat = sat32(dres.quot);
  assign wrap_now = wrap_res(dres.rem, dres.neg);

  // Mean travel, truncated toward zero
  assign dsum = 33'(d1) + 33'(q_sat);
  assign dsum_adj = dsum + (dsum[32] ? 33'sd1 : 33'sd0);
  assign dhalf = dsum_adj >>> 1;

  // Half of the differential speed for a velocity command
  assign hv = prod >>> (FRAC_BITS + 1);
  assign lsum = 64'(lin_cmd) - hv;
  assign rsum = 64'(lin_cmd) + hv;

  assign cs_start = (state == S_IDLE) && req_valid && (req.req_type == REQ_TICK);
  assign op_done = op_run && (mul_done || div_done);

  // Launch the shared units
  assign mul_start = !op_run
                     && (state inside {S_VMUL, S_AMUL, S_TMUL, S_TMUL2, S_XMUL, S_YMUL,
                                       S_LMUL, S_TMULR})
                     && (state != S_XMUL || cs_ok);
  assign div_start = !op_run
                     && (state inside {S_RATE, S_ADIV, S_AWRAP, S_TDIV, S_DA, S_HWRAP,
                                       S_LDIV, S_TDIVR})
                     && !(state == S_RATE && rad == '0)
                     && !(state == S_DA && sep == '0);

  // Operand selection per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_dvd = '0;
    div_dvs = '0;
    case (state)
      S_VMUL: begin
        mul_a = 33'(trn_cmd);
        mul_b = 33'(sep);
      end
      S_RATE: begin
        div_dvd = 64'(cur_cmd) <<< FRAC_BITS;
        div_dvs = DIV_W'(rad);
      end
      S_AMUL: begin
        mul_a = 33'(cur_w);
        mul_b = 33'(step_r);
      end
      S_ADIV: begin
        div_dvd = prod <<< ADV_SHIFT;
        div_dvs = DIV_W'(ADV_DIV);
      end
      S_AWRAP: begin
        div_dvd = 64'(cur_ang) + dres.quot + 64'(PI_Q28);
        div_dvs = TWO_PI_Q28;
      end
      S_TMUL: begin
        mul_a = 33'(rad);
        mul_b = 33'(cur_w);
      end
      S_TMUL2: begin
        mul_a = 33'(vt);
        mul_b = 33'(step_r);
      end
      S_TDIV: begin
        div_dvd = prod;
        div_dvs = DIV_W'(US_PER_S);
      end
      S_DA: begin
        div_dvd = (64'(d2) - 64'(d1)) <<< ANG_FRAC;
        div_dvs = DIV_W'(sep);
      end
      S_XMUL: begin
        mul_a = 33'(dr);
        mul_b = 33'(cos_v);
      end
      S_YMUL: begin
        mul_a = 33'(dr);
        mul_b = 33'(sin_v);
      end
      S_HWRAP: begin
        div_dvd = 64'(yaw) + 64'(da) + 64'(PI_Q28);
        div_dvs = TWO_PI_Q28;
      end
      S_LMUL: begin
        mul_a = 33'(dr);
        mul_b = 33'(US_PER_S);
      end
      S_LDIV: begin
        div_dvd = prod;
        div_dvs = DIV_W'(step_r);
      end
      S_TMULR: begin
        mul_a = 33'(da);
        mul_b = 33'(US_PER_S);
      end
      S_TDIVR: begin
        div_dvd = prod;
        div_dvs = DIV_W'(step_r) << TURN_SHIFT;
      end
      default: ;
    endcase
  end

  // Sequencer, state update and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sep <= 19'd15073;
      rad <= 17'd2294;
      tmo <= 24'd1000000;
      lcmd <= '0;
      rcmd <= '0;
      since <= '0;
      motors <= 1'b1;
      lang <= '0;
      rang <= '0;
      yaw <= '0;
      xpos <= '0;
      ypos <= '0;
      sd <= 1'b0;
      op_run <= 1'b0;
      cs_ok <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (mul_start || div_start) op_run <= 1'b1;
      if (op_done) op_run <= 1'b0;
      if (cs_done) cs_ok <= 1'b1;
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;

      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEP:     sep <= cfg_wdata[18:0];
          CFG_RADIUS:  rad <= cfg_wdata[16:0];
          CFG_TIMEOUT: tmo <= cfg_wdata;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: if (req_valid) begin
          case (req.req_type)
            REQ_TICK: begin
              step_r <= req.step_us;
              since <= since_new;
              if (since_new > tmo || !motors) begin
                lcmd <= '0;
                rcmd <= '0;
              end
              sd <= 1'b0;
              cs_ok <= 1'b0;
              state <= S_RATE;
            end
            REQ_VEL: begin
              lin_cmd <= req.linear_cmd;
              trn_cmd <= req.turn_cmd;
              state <= S_VMUL;
            end
            REQ_POWER: motors <= req.power_on;
            default: ;
          endcase
        end
        S_VMUL: if (op_done) begin
          lcmd <= sat32(lsum);
          rcmd <= sat32(rsum);
          since <= '0;
          state <= S_IDLE;
        end
        S_RATE: begin
          if (rad == '0) begin
            if (sd) wr <= '0;
            else wl <= '0;
            state <= S_AMUL;
          end else if (op_done) begin
            if (sd) wr <= q_sat;
            else wl <= q_sat;
            state <= S_AMUL;
          end
        end
        S_AMUL: if (op_done) state <= S_ADIV;
        S_ADIV: if (op_done) state <= S_AWRAP;
        S_AWRAP: if (op_done) begin
          if (sd) rang <= wrap_now;
          else lang <= wrap_now;
          state <= S_TMUL;
        end
        S_TMUL: if (op_done) begin
          vt <= sat32(prod >>> FRAC_BITS);
          state <= S_TMUL2;
        end
        S_TMUL2: if (op_done) state <= S_TDIV;
        S_TDIV: if (op_done) begin
          if (sd) begin
            d2 <= q_sat;
            dr <= dhalf[31:0];
            state <= S_DA;
          end else begin
            d1 <= q_sat;
            sd <= 1'b1;
            state <= S_RATE;
          end
        end
        S_DA: begin
          if (sep == '0) begin
            da <= '0;
            state <= S_XMUL;
          end else if (op_done) begin
            da <= q_sat;
            state <= S_XMUL;
          end
        end
        S_XMUL: if (op_done) begin
          xpos <= xpos + prod[ANG_FRAC+31:ANG_FRAC];
          state <= S_YMUL;
        end
        S_YMUL: if (op_done) begin
          ypos <= ypos + prod[ANG_FRAC+31:ANG_FRAC];
          state <= S_HWRAP;
        end
        S_HWRAP: if (op_done) begin
          yaw <= wrap_now;
          if (step_r == '0) begin
            lin_r <= '0;
            trn_r <= '0;
            state <= S_OUT;
          end else begin
            state <= S_LMUL;
          end
        end
        S_LMUL: if (op_done) state <= S_LDIV;
        S_LDIV: if (op_done) begin
          lin_r <= q_sat;
          state <= S_TMULR;
        end
        S_TMULR: if (op_done) state <= S_TDIVR;
        S_TDIVR: if (op_done) begin
          trn_r <= q_sat;
          state <= S_OUT;
        end
        S_OUT: if (!rsp_valid || !rsp_stall) begin
          rsp.left_rate <= wl;
          rsp.right_rate <= wr;
          rsp.left_angle <= lang;
          rsp.right_angle <= rang;
          rsp.pos_x <= xpos;
          rsp.pos_y <= ypos;
          rsp.heading <= yaw;
          rsp.linear_speed <= lin_r;
          rsp.turn_rate <= trn_r;
          rsp.motors_on <= motors;
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result transaction appears only from the output step
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_OUT))
    else $error("result loaded outside the output step");

  // Body motion starts only after both wheels are done
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DA) |-> sd)
    else $error("body step reached with left wheel only");

  // A tick with the motors off drops both speed commands
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.req_type == REQ_TICK && !motors)
    |=> (lcmd == '0 && rcmd == '0))
    else $error("speed commands kept with motors off");

  // Zero step time gives zero body speeds
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && step_r == '0) |-> (lin_r == '0 && trn_r == '0))
    else $error("nonzero speed for zero step time");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ddo_pkg::*;

  // Request code that the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 1300;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  diff_drive_odometry_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  req_t pending_reqs[$];
  rsp_t expected_odom[$];
  int   err_count = 0;

  // Append a transaction to the driver queue
  function automatic void queue_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  // Mirror of the base: geometry, timer, commands and pose
  longint      sep_m, radius_m, timeout_us;
  int          left_cmd, right_cmd;
  longint      idle_us;
  bit          motors_m;
  int          left_ang, right_ang, yaw_m;
  logic [31:0] x_m, y_m;

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int wrap_pi(longint a);
    longint m;
    longint s;
    m = 2 * longint'(PI_Q28);
    s = (a + PI_Q28) % m;
    if (s < 0) s += m;
    return int'(s - PI_Q28);
  endfunction

  function automatic int rate_of(int v);
    if (radius_m == 0) return 0;
    return int'(clamp_s32((longint'(v) * (64'sd1 <<< FRAC_BITS)) / radius_m));
  endfunction

  function automatic int advance_angle(int ang, int w, longint step);
    longint p;
    longint sc;
    longint delta;
    p = longint'(w) * step;
    sc = 64'sd1 <<< ADV_SHIFT;
    delta = (p / ADV_DIV) * sc + ((p % ADV_DIV) * sc) / ADV_DIV;
    return wrap_pi(longint'(ang) + delta);
  endfunction

  function automatic longint travel_of(int w, longint step);
    longint v;
    v = clamp_s32((radius_m * longint'(w)) >>> FRAC_BITS);
    return clamp_s32((v * step) / US_PER_S);
  endfunction

  // Heading sin/cos, fixed gain, folded into the right half plane
  function automatic void sin_cos(int ang, output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint t;
    bit     flip;
    z = ang;
    x = CORDIC_GAIN_Q28;
    y = 0;
    flip = 0;
    if (z > HALF_PI_Q28) begin
      z -= PI_Q28;
      flip = 1;
    end else if (z < -HALF_PI_Q28) begin
      z += PI_Q28;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 28; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(ATAN_Q28[i]);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(ATAN_Q28[i]);
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic void reset_base();
    sep_m = 15073;
    radius_m = 2294;
    timeout_us = 1000000;
    left_cmd = 0;
    right_cmd = 0;
    idle_us = 0;
    motors_m = 1;
    left_ang = 0;
    right_ang = 0;
    yaw_m = 0;
    x_m = '0;
    y_m = '0;
  endfunction

  // Advance the base by one accepted transaction
  function automatic void drive_base(req_t r);
    longint h, step, d1, d2, dr, da, c, s, lin, turn;
    int     wl, wr;
    rsp_t   o;
    step = r.step_us;
    if (r.req_type == REQ_VEL) begin
      h = (longint'(r.turn_cmd) * sep_m) >>> (FRAC_BITS + 1);
      left_cmd = int'(clamp_s32(longint'(r.linear_cmd) - h));
      right_cmd = int'(clamp_s32(longint'(r.linear_cmd) + h));
      idle_us = 0;
    end else if (r.req_type == REQ_POWER) begin
      motors_m = r.power_on;
    end else if (r.req_type == REQ_TICK) begin
      idle_us += step;
      if (idle_us > TIMER_MAX) idle_us = TIMER_MAX;
      if (idle_us > timeout_us || !motors_m) begin
        left_cmd = 0;
        right_cmd = 0;
      end
      wl = rate_of(left_cmd);
      wr = rate_of(right_cmd);
      left_ang = advance_angle(left_ang, wl, step);
      right_ang = advance_angle(right_ang, wr, step);
      d1 = travel_of(wl, step);
      d2 = travel_of(wr, step);
      dr = (d1 + d2) / 2;
      da = 0;
      if (sep_m != 0) da = clamp_s32(((d2 - d1) * (64'sd1 <<< 28)) / sep_m);
      sin_cos(yaw_m, c, s);
      x_m += 32'((dr * c) >>> 28);
      y_m += 32'((dr * s) >>> 28);
      yaw_m = wrap_pi(longint'(yaw_m) + da);
      lin = 0;
      turn = 0;
      if (step != 0) begin
        lin = (dr * US_PER_S) / step;
        turn = (da * US_PER_S) / (step * (64'sd1 <<< TURN_SHIFT));
      end
      o.left_rate = wl;
      o.right_rate = wr;
      o.left_angle = left_ang;
      o.right_angle = right_ang;
      o.pos_x = x_m;
      o.pos_y = y_m;
      o.heading = yaw_m;
      o.linear_speed = 32'(clamp_s32(lin));
      o.turn_rate = 32'(clamp_s32(turn));
      o.motors_on = motors_m;
      expected_odom = {expected_odom, o};
    end
  endfunction

  function automatic void check_field(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0d actual %0d", $time, nm, $signed(e), $signed(a));
      err_count++;
    end
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic req_t make_req(logic [1:0] kind, logic [23:0] step,
                                    logic [31:0] lin, logic [31:0] turn, logic pwr);
    req_t r;
    r.req_type = kind;
    r.step_us = step;
    r.linear_cmd = lin;
    r.turn_cmd = turn;
    r.power_on = pwr;
    return r;
  endfunction

  // Mostly ticks and velocity commands with plausible speeds, some wild values
  function automatic req_t random_req();
    int          pick;
    logic [23:0] step;
    logic [31:0] lin;
    logic [31:0] turn;
    pick = $urandom_range(0, 99);
    step = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 60000));
    if ($urandom_range(0, 5) == 0) begin
      lin = $urandom;
      turn = $urandom;
    end else begin
      lin = 32'($signed($urandom_range(0, 393216)) - 196608);
      turn = 32'($signed($urandom_range(0, 786432)) - 393216);
    end
    if (pick < 56) return make_req(REQ_TICK, step, $urandom, $urandom, 1'($urandom));
    if (pick < 86) return make_req(REQ_VEL, 24'($urandom), lin, turn, 1'($urandom));
    if (pick < 96)
      return make_req(REQ_POWER, 24'($urandom), $urandom, $urandom,
                      $urandom_range(0, 3) != 0);
    return make_req(REQ_UNUSED, 24'($urandom), $urandom, $urandom, 1'($urandom));
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Request driver: hold while stalled, insert random gaps between transactions
  int send_wait = 0;
  bit send_calm = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      if (req_valid && !req_stall) drive_base(req);
      if (!req_valid || !req_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_wait = draw_gap(send_calm);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest expected pose, then stall a while
  int   hold_cnt = 0;
  bit   hold_calm = 0;
  rsp_t want;
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_odom.size() == 0) begin
          $display("%0t: unexpected result, expected none actual heading %0d",
                   $time, rsp.heading);
          err_count++;
        end else begin
          want = expected_odom.pop_front();
          check_field("left_rate", want.left_rate, rsp.left_rate);
          check_field("right_rate", want.right_rate, rsp.right_rate);
          check_field("left_angle", want.left_angle, rsp.left_angle);
          check_field("right_angle", want.right_angle, rsp.right_angle);
          check_field("pos_x", want.pos_x, rsp.pos_x);
          check_field("pos_y", want.pos_y, rsp.pos_y);
          check_field("heading", want.heading, rsp.heading);
          check_field("linear_speed", want.linear_speed, rsp.linear_speed);
          check_field("turn_rate", want.turn_rate, rsp.turn_rate);
          check_field("motors_on", 32'(want.motors_on), 32'(rsp.motors_on));
        end
        if ($urandom_range(0, 29) == 0) hold_calm = !hold_calm;
        hold_cnt = draw_gap(hold_calm);
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      rsp_stall <= (hold_cnt > 0);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    if (idx == CFG_SEP) sep_m = val & 32'h7FFFF;
    else if (idx == CFG_RADIUS) radius_m = val & 32'h1FFFF;
    else if (idx == CFG_TIMEOUT) timeout_us = val & 32'hFFFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every queued transaction and pose, then let the block go quiet
  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_odom.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) queue_req(random_req());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reset_base();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: default geometry
    queue_req(make_req(REQ_TICK, 24'd0, 0, 0, 0));
    queue_req(make_req(REQ_VEL, 0, 32'sd65536, 0, 0));
    queue_req(make_req(REQ_TICK, 24'd33333, 0, 0, 0));
    queue_req(make_req(REQ_VEL, 0, 32'sd131072, 32'sd65536, 0));
    queue_req(make_req(REQ_TICK, 24'd33333, 0, 0, 0));
    queue_req(make_req(REQ_TICK, 24'd0, 0, 0, 0));
    queue_req(make_req(REQ_TICK, 24'hFFFFFF, 0, 0, 0));
    queue_req(make_req(REQ_TICK, 24'hFFFFFF, 0, 0, 0));
    queue_req(make_req(REQ_VEL, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
    queue_req(make_req(REQ_TICK, 24'd1000, 0, 0, 0));
    queue_req(make_req(REQ_VEL, 0, 32'h80000000, 32'h80000000, 0));
    queue_req(make_req(REQ_TICK, 24'd1000, 0, 0, 0));
    queue_req(make_req(REQ_VEL, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1));
    queue_req(make_req(REQ_TICK, 24'd50000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1));
    queue_req(make_req(REQ_POWER, 0, 0, 0, 1'b0));
    queue_req(make_req(REQ_TICK, 24'd1000, 0, 0, 0));
    queue_req(make_req(REQ_POWER, 0, 0, 0, 1'b1));
    queue_req(make_req(REQ_VEL, 0, -32'sd65536, 32'sd98304, 0));
    queue_req(make_req(REQ_TICK, 24'd20000, 0, 0, 0));
    queue_req(make_req(REQ_UNUSED, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1));
    queue_req(make_req(REQ_TICK, 24'd1, 0, 0, 0));
    run_random(230);

    // Smallest geometry, timeout fires on any elapsed time
    write_reg(CFG_SEP, 656);
    write_reg(CFG_RADIUS, 66);
    write_reg(CFG_TIMEOUT, 0);
    run_random(230);

    // Largest geometry, timer saturates but never times out
    write_reg(CFG_SEP, 327680);
    write_reg(CFG_RADIUS, 65536);
    write_reg(CFG_TIMEOUT, 24'hFFFFFF);
    queue_req(make_req(REQ_VEL, 0, 32'sd65536, 32'sd65536, 0));
    queue_req(make_req(REQ_TICK, 24'hFFFFFF, 0, 0, 0));
    queue_req(make_req(REQ_TICK, 24'hFFFFFF, 0, 0, 0));
    queue_req(make_req(REQ_TICK, 24'd30000, 0, 0, 0));
    run_random(230);

    // Degenerate geometry: zero radius and zero separation
    write_reg(CFG_SEP, 0);
    write_reg(CFG_RADIUS, 0);
    write_reg(CFG_TIMEOUT, 500000);
    run_random(120);
    write_reg(CFG_RADIUS, 2294);
    run_random(120);

    // Random geometry
    repeat (3) begin
      write_reg(CFG_SEP, $urandom_range(656, 327680));
      write_reg(CFG_RADIUS, $urandom_range(66, 65536));
      write_reg(CFG_TIMEOUT, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                         : $urandom_range(20000, 2000000));
      run_random(175);
    end

    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #100_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
